FILE: rtl/cbtmx_pkg.sv
`timescale 1ns / 1ps

package cbtmx_pkg;

  localparam int unsigned KEY_BITS   = 18;
  localparam int unsigned NODE_SLOTS = 4096;
  localparam int unsigned COUNT_BITS = 16;

  // Port field widths are fixed.
  localparam int unsigned KEY_IN_W = 18;
  localparam int unsigned OUT_W    = 18;

  localparam int unsigned NODE_W = $clog2(NODE_SLOTS);
  localparam int unsigned FREE_W = $clog2(NODE_SLOTS + 1);
  localparam int unsigned POS_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned NEED_W = $clog2(KEY_BITS + 1);
  localparam int unsigned SUM_W  = FREE_W + NEED_W;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [OUT_W-1:0]      xor_t;
  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [FREE_W-1:0]     free_t;
  typedef logic [POS_W-1:0]      pos_t;

  typedef struct packed {
    node_t zc;
    node_t oc;
    cnt_t  cnt;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_QUERY
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_ABSENT,
    ST_FULL
  } status_e;

endpackage

FILE: rtl/cbtmx_ram.sv
`timescale 1ns / 1ps

module cbtmx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/counted_binary_trie_max_xor_unit.sv
`timescale 1ns / 1ps

// Binary trie over KEY_BITS-bit keys with a live count per node; commands insert, remove and
// max-xor query, one result beat per input beat. The root sits in flops, all other nodes in a
// one-write, two-read node RAM; both children of the current node are read together and the
// next pair of addresses comes straight off the RAM output. Insert and remove first walk the
// path to check it (no state touched on error), then walk it again writing counts back; an
// insert that allocates new nodes stops its check walk at the first missing child and does
// one write per new node. Errors end the walk early. Nodes are never freed. Input stall is
// high from acceptance until the result moves into the output register.
module counted_binary_trie_max_xor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [17:0] key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [17:0] best_xor_o,
  output logic [1:0]  status_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROOT  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]               state_q, state_d;
  logic                     commit_q, commit_d;
  cbtmx_pkg::cmd_e          cmd_q, cmd_d;
  cbtmx_pkg::key_t          key_q, key_d;
  cbtmx_pkg::pos_t          pos_q, pos_d;
  cbtmx_pkg::pos_t          apos_q, apos_d;
  cbtmx_pkg::node_t         par_zc_q, par_zc_d;
  cbtmx_pkg::node_t         par_oc_q, par_oc_d;
  cbtmx_pkg::key_t          res_q, res_d;
  cbtmx_pkg::status_e       stat_q, stat_d;
  cbtmx_pkg::entry_t        root_q, root_d;
  cbtmx_pkg::free_t         free_q, free_d;
  logic                     out_valid_q, out_valid_d;
  cbtmx_pkg::xor_t          best_xor_q, best_xor_d;
  cbtmx_pkg::status_e       status_q, status_d;

  logic                     ram_we;
  cbtmx_pkg::node_t         ram_waddr;
  cbtmx_pkg::entry_t        ram_wdata;
  cbtmx_pkg::node_t         ram_raddr_a;
  cbtmx_pkg::node_t         ram_raddr_b;
  cbtmx_pkg::entry_t        rd_a;
  cbtmx_pkg::entry_t        rd_b;

  cbtmx_ram #(
    .WIDTH (cbtmx_pkg::ENTRY_W),
    .DEPTH (cbtmx_pkg::NODE_SLOTS)
  ) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (rd_b)
  );

  function automatic logic fits(input cbtmx_pkg::free_t f,
                                input logic [cbtmx_pkg::NEED_W-1:0] n);
    logic [cbtmx_pkg::SUM_W-1:0] s;
    s = cbtmx_pkg::SUM_W'(f) + cbtmx_pkg::SUM_W'(n);
    return s <= cbtmx_pkg::SUM_W'(cbtmx_pkg::NODE_SLOTS);
  endfunction

  // Walk context: the current node's children, just read from the two RAM ports.
  logic                     bit_b;
  logic                     bit_nb;
  logic                     bit_ab;
  logic                     root_b;
  cbtmx_pkg::pos_t          pos_m1;
  cbtmx_pkg::pos_t          apos_m1;
  cbtmx_pkg::node_t         c_idx;
  cbtmx_pkg::node_t         o_idx;
  cbtmx_pkg::node_t         root_c;
  cbtmx_pkg::entry_t        e;
  cbtmx_pkg::entry_t        oe;
  cbtmx_pkg::entry_t        take;
  cbtmx_pkg::entry_t        wr;
  logic                     take_opp;
  logic                     out_free;

  assign pos_m1   = pos_q - cbtmx_pkg::POS_W'(1);
  assign apos_m1  = apos_q - cbtmx_pkg::POS_W'(1);
  assign bit_b    = key_q[pos_q];
  assign bit_nb   = key_q[pos_m1];
  assign bit_ab   = key_q[apos_m1];
  assign root_b   = key_q[cbtmx_pkg::KEY_BITS-1];
  assign root_c   = root_b ? root_q.oc : root_q.zc;
  assign c_idx    = bit_b ? par_oc_q : par_zc_q;
  assign o_idx    = bit_b ? par_zc_q : par_oc_q;
  assign e        = bit_b ? rd_b : rd_a;
  assign oe       = bit_b ? rd_a : rd_b;
  // only a query may leave the key path
  assign take_opp = (cmd_q == cbtmx_pkg::CMD_QUERY) && (o_idx != '0) && (oe.cnt != '0);
  assign take     = take_opp ? oe : e;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    commit_d    = commit_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pos_d       = pos_q;
    apos_d      = apos_q;
    par_zc_d    = par_zc_q;
    par_oc_d    = par_oc_q;
    res_d       = res_q;
    stat_d      = stat_q;
    root_d      = root_q;
    free_d      = free_q;
    out_valid_d = out_valid_q && out_stall_i;
    best_xor_d  = best_xor_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    wr          = e;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cbtmx_pkg::cmd_e'(cmd_i);
          key_d    = cbtmx_pkg::key_t'(key_i);
          res_d    = '0;
          stat_d   = cbtmx_pkg::ST_OK;
          commit_d = 1'b0;
          state_d  = S_ROOT;
        end
      end

      S_ROOT: begin
        ram_raddr_a = root_q.zc;
        ram_raddr_b = root_q.oc;
        par_zc_d    = root_q.zc;
        par_oc_d    = root_q.oc;
        pos_d       = cbtmx_pkg::POS_W'(cbtmx_pkg::KEY_BITS - 1);
        case (cmd_q)
          cbtmx_pkg::CMD_INSERT: begin
            if (commit_q) begin
              root_d.cnt = root_q.cnt + cbtmx_pkg::COUNT_BITS'(1);
              if (root_c == '0) begin
                if (root_b) begin
                  root_d.oc = cbtmx_pkg::NODE_W'(free_q);
                end else begin
                  root_d.zc = cbtmx_pkg::NODE_W'(free_q);
                end
                apos_d  = cbtmx_pkg::POS_W'(cbtmx_pkg::KEY_BITS - 1);
                state_d = S_ALLOC;
              end else begin
                state_d = S_WALK;
              end
            end else if (&root_q.cnt) begin
              stat_d  = cbtmx_pkg::ST_FULL;
              state_d = S_DONE;
            end else if (root_c == '0) begin
              if (fits(free_q, cbtmx_pkg::NEED_W'(cbtmx_pkg::KEY_BITS))) begin
                commit_d = 1'b1;
              end else begin
                stat_d  = cbtmx_pkg::ST_FULL;
                state_d = S_DONE;
              end
            end else begin
              state_d = S_WALK;
            end
          end
          cbtmx_pkg::CMD_REMOVE: begin
            if (commit_q) begin
              root_d.cnt = root_q.cnt - cbtmx_pkg::COUNT_BITS'(1);
              state_d    = S_WALK;
            end else if (root_q.cnt == '0 || root_c == '0) begin
              stat_d  = cbtmx_pkg::ST_ABSENT;
              state_d = S_DONE;
            end else begin
              state_d = S_WALK;
            end
          end
          cbtmx_pkg::CMD_QUERY: begin
            if (root_q.cnt == '0) begin
              stat_d  = cbtmx_pkg::ST_EMPTY;
              state_d = S_DONE;
            end else begin
              state_d = S_WALK;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        // descend by default; arms that stop override state
        ram_raddr_a = take.zc;
        ram_raddr_b = take.oc;
        par_zc_d    = take.zc;
        par_oc_d    = take.oc;
        pos_d       = pos_m1;
        case (cmd_q)
          cbtmx_pkg::CMD_INSERT: begin
            if (commit_q) begin
              wr.cnt    = e.cnt + cbtmx_pkg::COUNT_BITS'(1);
              ram_we    = 1'b1;
              ram_waddr = c_idx;
              ram_wdata = wr;
              if (pos_q == '0) begin
                state_d = S_DONE;
              end else if ((bit_nb ? e.oc : e.zc) == '0) begin
                if (bit_nb) begin
                  wr.oc = cbtmx_pkg::NODE_W'(free_q);
                end else begin
                  wr.zc = cbtmx_pkg::NODE_W'(free_q);
                end
                ram_wdata = wr;
                apos_d    = pos_m1;
                state_d   = S_ALLOC;
              end
            end else if (c_idx == '0) begin
              if (fits(free_q, cbtmx_pkg::NEED_W'(pos_q) + cbtmx_pkg::NEED_W'(1))) begin
                commit_d = 1'b1;
                state_d  = S_ROOT;
              end else begin
                stat_d  = cbtmx_pkg::ST_FULL;
                state_d = S_DONE;
              end
            end else if (&e.cnt) begin
              stat_d  = cbtmx_pkg::ST_FULL;
              state_d = S_DONE;
            end else if (pos_q == '0) begin
              commit_d = 1'b1;
              state_d  = S_ROOT;
            end
          end
          cbtmx_pkg::CMD_REMOVE: begin
            if (commit_q) begin
              wr.cnt    = e.cnt - cbtmx_pkg::COUNT_BITS'(1);
              ram_we    = 1'b1;
              ram_waddr = c_idx;
              ram_wdata = wr;
              if (pos_q == '0) begin
                state_d = S_DONE;
              end
            end else if (c_idx == '0 || e.cnt == '0) begin
              stat_d  = cbtmx_pkg::ST_ABSENT;
              state_d = S_DONE;
            end else if (pos_q == '0) begin
              commit_d = 1'b1;
              state_d  = S_ROOT;
            end
          end
          cbtmx_pkg::CMD_QUERY: begin
            if (take_opp) begin
              res_d = res_q | (cbtmx_pkg::key_t'(1) << pos_q);
            end
            if ((!take_opp && c_idx == '0) || pos_q == '0) begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_ALLOC: begin
        // fresh node: count one, link to the next fresh node unless it is a leaf
        ram_we        = 1'b1;
        ram_waddr     = cbtmx_pkg::NODE_W'(free_q);
        ram_wdata     = '0;
        ram_wdata.cnt = cbtmx_pkg::COUNT_BITS'(1);
        free_d        = free_q + cbtmx_pkg::FREE_W'(1);
        if (apos_q == '0) begin
          state_d = S_DONE;
        end else begin
          if (bit_ab) begin
            ram_wdata.oc = cbtmx_pkg::NODE_W'(free_q + cbtmx_pkg::FREE_W'(1));
          end else begin
            ram_wdata.zc = cbtmx_pkg::NODE_W'(free_q + cbtmx_pkg::FREE_W'(1));
          end
          apos_d = apos_m1;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          best_xor_d  = cbtmx_pkg::xor_t'(res_q);
          status_d    = stat_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      commit_q    <= 1'b0;
      root_q      <= '0;
      free_q      <= cbtmx_pkg::FREE_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      commit_q    <= commit_d;
      root_q      <= root_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    pos_q      <= pos_d;
    apos_q     <= apos_d;
    par_zc_q   <= par_zc_d;
    par_oc_q   <= par_oc_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    best_xor_q <= best_xor_d;
    status_q   <= status_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign best_xor_o  = best_xor_q;
  assign status_o    = status_q;

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q != '0) && (cbtmx_pkg::SUM_W'(free_q) <= cbtmx_pkg::SUM_W'(cbtmx_pkg::NODE_SLOTS)))
    else $error("free pointer out of range");

  a_no_root_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr != '0))
    else $error("node RAM write to root slot");

  a_alloc_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |-> (commit_q && cmd_q == cbtmx_pkg::CMD_INSERT &&
                              cbtmx_pkg::SUM_W'(free_q) <
                              cbtmx_pkg::SUM_W'(cbtmx_pkg::NODE_SLOTS)))
    else $error("allocation outside an insert commit or past capacity");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q) == S_DONE))
    else $error("result beat without a finished command");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != cbtmx_pkg::ST_OK) |-> (best_xor_o == '0))
    else $error("error result carries nonzero best_xor");

endmodule
